// ===== rtl/sks_pkg.sv =====
package sks_pkg;

	localparam int KEY_W = 16;
	localparam int POS_W = 12;
	localparam int CNT_W = 13;
	localparam int IDX_W = 12;
	localparam int DEFAULT_DEPTH = 4096;

	localparam logic [KEY_W-1:0] KEY_LIMIT = 16'hFFF1;
	localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic write;          // store one key into the table
		logic capture;        // latch lookup key, read entry 0
		logic init;           // open the search window, read first midpoint
		logic step;           // narrow the window, read next midpoint
		logic set_result;     // latch the lookup answer
		logic result_found;
		logic result_from_mid;
		logic push;           // move the answer into the output register
	} sks_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic probe_eq;       // read entry equals the lookup key
		logic key_high;       // key at or above the search limit
		logic range_empty;    // window closes after this probe
		logic out_free;       // output register can take a beat
	} sks_sts_t;

endpackage

// ===== rtl/sks_ctrl.sv =====
module sks_ctrl
	import sks_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     command,
	input  sks_sts_t sts,
	output logic     in_stall,
	output sks_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHK0 = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	logic [1:0] st_q;
	logic [1:0] st_d;

	assign in_stall = (st_q != ST_IDLE);

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_LOAD) begin
						cmd.write = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						st_d        = ST_CHK0;
					end
				end
			end
			ST_CHK0: begin
				// entry 0 match wins over the key limit
				if (sts.probe_eq) begin
					cmd.set_result   = 1'b1;
					cmd.result_found = 1'b1;
					st_d             = ST_PUSH;
				end else if (sts.key_high) begin
					cmd.set_result = 1'b1;
					st_d           = ST_PUSH;
				end else begin
					cmd.init = 1'b1;
					st_d     = ST_SRCH;
				end
			end
			ST_SRCH: begin
				if (sts.probe_eq) begin
					cmd.set_result      = 1'b1;
					cmd.result_found    = 1'b1;
					cmd.result_from_mid = 1'b1;
					st_d                = ST_PUSH;
				end else if (sts.range_empty) begin
					cmd.set_result = 1'b1;
					st_d           = ST_PUSH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

`ifndef SYNTH
	a_capture_to_chk0: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (st_q == ST_CHK0))
		else $error("lookup start did not move to entry 0 check");

	a_result_to_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_result |=> (st_q == ST_PUSH))
		else $error("latched answer not followed by push");

	a_push_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PUSH && sts.out_free) |=> (st_q == ST_IDLE))
		else $error("push with free output did not return to idle");
`endif

endmodule

// ===== rtl/sks_dp.sv =====
module sks_dp
	import sks_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sks_cmd_t         cmd,
	output sks_sts_t         sts,
	input  logic [POS_W-1:0] entry_position,
	input  logic [KEY_W-1:0] key_value,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [IDX_W-1:0] match_index,
	output logic             found
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW = AW + 1;
	localparam int XW = (IW > CNT_W) ? IW : CNT_W;
	localparam int PW = (IW > POS_W) ? IW : POS_W;

	logic [KEY_W-1:0] key_mem_q [TABLE_DEPTH];
	logic [KEY_W-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;

	logic [CNT_W-1:0] entry_count_q;
	logic [KEY_W-1:0] key_q;
	logic [IW-1:0]    lo_q;
	logic [IW-1:0]    hi1_q;
	logic [AW-1:0]    mid_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             res_found_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] match_index_q;
	logic             found_q;

	logic [XW-1:0]          cnt_x;
	logic [XW-1:0]          live_x;
	logic [IW-1:0]          live;
	logic [IW-1:0]          live_m1;
	logic [AW-1:0]          first_mid;
	logic                   probe_lt;
	logic [IW-1:0]          nlo;
	logic [IW-1:0]          nhi;
	logic [IW:0]            nsum;
	logic [AW-1:0]          next_mid;
	logic                   pos_ok;
	logic [AW+POS_W-1:0]    pos_ext;
	logic [AW+IDX_W-1:0]    mid_ext;

	// clamp the configured count into 1..TABLE_DEPTH
	assign cnt_x  = XW'(entry_count_q);
	assign live_x = (cnt_x == '0) ? XW'(1) :
		(cnt_x > XW'(TABLE_DEPTH)) ? XW'(TABLE_DEPTH) : cnt_x;
	assign live      = live_x[IW-1:0];
	assign live_m1   = live - IW'(1);
	assign first_mid = live_m1[AW:1];

	// window is [lo, hi1), midpoint is floor((lo + hi1 - 1) / 2)
	assign probe_lt = (rd_data_q < key_q);
	assign nlo      = probe_lt ? ({1'b0, mid_q} + IW'(1)) : lo_q;
	assign nhi      = probe_lt ? hi1_q : {1'b0, mid_q};
	assign nsum     = {1'b0, nlo} + {1'b0, nhi} - (IW+1)'(1);
	assign next_mid = nsum[AW:1];

	assign sts.probe_eq    = (rd_data_q == key_q);
	assign sts.key_high    = (key_q >= KEY_LIMIT);
	assign sts.range_empty = (nlo >= nhi);
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign pos_ok  = (PW'(entry_position) < PW'(TABLE_DEPTH));
	assign pos_ext = {{AW{1'b0}}, entry_position};
	assign mid_ext = {{IDX_W{1'b0}}, mid_q};

	always_comb begin
		if (cmd.capture) begin
			rd_addr = '0;
		end else if (cmd.init) begin
			rd_addr = first_mid;
		end else if (cmd.step) begin
			rd_addr = next_mid;
		end else begin
			rd_addr = mid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && pos_ok) begin
			key_mem_q[pos_ext[AW-1:0]] <= key_value;
		end
		rd_data_q <= key_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= key_value;
		end
		if (cmd.init) begin
			lo_q  <= '0;
			hi1_q <= live;
			mid_q <= first_mid;
		end else if (cmd.step) begin
			lo_q  <= nlo;
			hi1_q <= nhi;
			mid_q <= next_mid;
		end
		if (cmd.set_result) begin
			res_idx_q   <= cmd.result_from_mid ? mid_ext[IDX_W-1:0] : '0;
			res_found_q <= cmd.result_found;
		end
		if (cmd.push) begin
			match_index_q <= res_idx_q;
			found_q       <= res_found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CNT_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				entry_count_q <= cfg_wdata;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign match_index = match_index_q;
	assign found       = found_q;

`ifndef SYNTH
	a_mid_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.init || cmd.step) |=> ({1'b0, mid_q} >= lo_q && {1'b0, mid_q} < hi1_q))
		else $error("probe midpoint outside search window");

	a_push_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid_q)
		else $error("pushed answer not presented");

	a_push_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || !out_stall))
		else $error("push would overwrite a pending beat");
`endif

endmodule

// ===== rtl/sorted_key_binary_search.sv =====
// sorted key table with binary search lookup. a load beat (command 0) writes key_value
// at entry_position and gives no result; positions at or past TABLE_DEPTH
// are dropped. a lookup beat (command 1) searches the first entry_count keys, which must
// be loaded in ascending order, and gives one output beat: the matching index with found
// high, or index 0 with found low. a key equal to entry 0 always answers index 0, found
// high; any other key of 0xfff1 or above answers index 0, found low, without a search.
// entry_count is clamped to 1..TABLE_DEPTH and may only be written while the block is
// idle. one lookup at a time through a single read port on the key memory.
// after a lookup beat is taken, in_stall stays high through the entry 0 check, the p probes
// (p at most floor(log2(entry_count)) + 1, 13 for a full 4096-entry table) and the push;
// the early answers make no probe. the push waits while an earlier answer still sits
// stalled in the output register. a load does not raise in_stall. the answer sits in an
// output register, so loads keep flowing while a result waits to be taken.
module sorted_key_binary_search
	import sks_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration: entry_count
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             command,
	input  logic [POS_W-1:0] entry_position,
	input  logic [KEY_W-1:0] key_value,
	// output channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] match_index,
	output logic             found
);

	sks_cmd_t cmd;
	sks_sts_t sts;

	// sequencer: idle, entry 0 check, one probe per cycle, push to output
	sks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// key memory, search window registers and output register
	sks_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.entry_position (entry_position),
		.key_value      (key_value),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.match_index    (match_index),
		.found          (found)
	);

endmodule

// ===== tb/sorted_key_binary_search_tb.sv =====
module sorted_key_binary_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sks_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int RANDOM_ITEMS = 1400;

	// lookup answer as the block reports it
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             hit;
	} answer_t;

	// kinds of rows in the directed plan
	typedef enum logic [1:0] {
		ROW_LOAD,
		ROW_FIND,
		ROW_COUNT
	} row_kind_e;

	typedef struct packed {
		row_kind_e        kind;
		logic [POS_W-1:0] pos;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
		logic             typed;     // answer below is fixed, not predicted
		logic [IDX_W-1:0] want_idx;
		logic             want_hit;
	} plan_row_t;

	// directed plan, run after the whole table is loaded with ascending keys
	// entry 0 = 0x0000, entry 1 = 0x0013, entry 2048 = 0x8000, entry 4095 = 0xfff0
	localparam plan_row_t PLAN [0:24] = '{
		// reset count, full table
		'{ROW_FIND,  12'd0,    16'h0000, 13'd0,    1'b1, 12'd0,    1'b1},
		'{ROW_FIND,  12'd0,    16'hFFF0, 13'd0,    1'b1, 12'd4095, 1'b1},
		'{ROW_FIND,  12'd0,    16'hFFF1, 13'd0,    1'b1, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'hFFFF, 13'd0,    1'b1, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'h0014, 13'd0,    1'b1, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'h0013, 13'd0,    1'b0, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'h8000, 13'd0,    1'b0, 12'd0,    1'b0},
		'{ROW_LOAD,  12'd4095, 16'hFFF0, 13'd0,    1'b0, 12'd0,    1'b0},
		'{ROW_LOAD,  12'd0,    16'h0000, 13'd0,    1'b0, 12'd0,    1'b0},
		// count of zero acts as one, entry 0 above the limit still matches
		'{ROW_COUNT, 12'd0,    16'h0000, 13'd0,    1'b0, 12'd0,    1'b0},
		'{ROW_LOAD,  12'd0,    16'hFFF5, 13'd0,    1'b0, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'hFFF5, 13'd0,    1'b1, 12'd0,    1'b1},
		'{ROW_FIND,  12'd0,    16'hFFF8, 13'd0,    1'b1, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'h0013, 13'd0,    1'b1, 12'd0,    1'b0},
		'{ROW_LOAD,  12'd0,    16'h0000, 13'd0,    1'b0, 12'd0,    1'b0},
		// oversized count saturates to the full table
		'{ROW_COUNT, 12'd0,    16'h0000, 13'd8191, 1'b0, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'hFFF0, 13'd0,    1'b1, 12'd4095, 1'b1},
		'{ROW_FIND,  12'd0,    16'h8000, 13'd0,    1'b0, 12'd0,    1'b0},
		'{ROW_COUNT, 12'd0,    16'h0000, 13'd1,    1'b0, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'h0000, 13'd0,    1'b1, 12'd0,    1'b1},
		'{ROW_COUNT, 12'd0,    16'h0000, 13'd2,    1'b0, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'h0013, 13'd0,    1'b1, 12'd1,    1'b1},
		'{ROW_FIND,  12'd0,    16'h0012, 13'd0,    1'b1, 12'd0,    1'b0},
		'{ROW_COUNT, 12'd0,    16'h0000, 13'd4096, 1'b0, 12'd0,    1'b0},
		'{ROW_FIND,  12'd0,    16'h0013, 13'd0,    1'b0, 12'd0,    1'b0}
	};

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             command = CMD_LOAD;
	logic [POS_W-1:0] entry_position = '0;
	logic [KEY_W-1:0] key_value = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [IDX_W-1:0] match_index;
	logic             found;

	// predictor state: our copy of the key table and the clamped entry count
	logic [KEY_W-1:0] key_mem [DEFAULT_DEPTH];
	logic [KEY_W-1:0] fill_keys [DEFAULT_DEPTH];
	int               live_entries = DEFAULT_DEPTH;

	answer_t pending_answers [$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	bit      in_calm = 1'b0;
	bit      out_calm = 1'b0;
	int      out_hold = 0;

	sorted_key_binary_search dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.entry_position(entry_position),
		.key_value     (key_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.match_index   (match_index),
		.found         (found)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// binary search over the live prefix of the table
	function automatic answer_t search_table(input logic [KEY_W-1:0] key);
		answer_t ans;
		int      lo;
		int      hi;
		int      mid;
		ans = '0;
		lo = 0;
		hi = live_entries - 1;
		// equality with entry 0 wins over the limit
		if (key == key_mem[0]) begin
			ans.hit = 1'b1;
			return ans;
		end
		if (key >= KEY_LIMIT)
			return ans;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (key_mem[mid] == key) begin
				ans.idx = IDX_W'(mid);
				ans.hit = 1'b1;
				return ans;
			end
			if (key_mem[mid] < key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return ans;
	endfunction

	// lookup keys: mostly table hits, some neighbors, noise and keys near the limit
	function automatic logic [KEY_W-1:0] pick_key(input int span);
		logic [KEY_W-1:0] k;
		k = key_mem[$urandom_range(0, span - 1)];
		case ($urandom_range(0, 9))
			6: k = k + 1'b1;
			7: k = k - 1'b1;
			8: k = KEY_W'($urandom);
			9: k = KEY_W'($urandom_range(16'hFFF0, 16'hFFFF));
			default: ;
		endcase
		return k;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// one input beat; called at a rising edge, returns at the edge that took it
	task automatic send_beat(input logic cmd, input logic [POS_W-1:0] pos,
			input logic [KEY_W-1:0] key, input bit typed = 1'b0,
			input logic [IDX_W-1:0] want_idx = '0, input logic want_hit = 1'b0);
		int gap;
		if ($urandom_range(0, 49) == 0)
			in_calm = ~in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		entry_position <= pos;
		key_value <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// beat taken at this edge: update the predictor
		if (cmd == CMD_LOAD)
			key_mem[pos] = key;
		else if (typed)
			pending_answers.push_back('{idx: want_idx, hit: want_hit});
		else
			pending_answers.push_back(search_table(key));
	endtask

	// entry_count is written only with the block idle
	task automatic set_entry_count(input logic [CNT_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (value == '0)
			live_entries = 1;
		else if (int'(value) > DEFAULT_DEPTH)
			live_entries = DEFAULT_DEPTH;
		else
			live_entries = int'(value);
	endtask

	// output side: random stall per result, compare against the oldest answer
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_answers.size() == 0) begin
					note_mismatch("unexpected result index", match_index, 0);
				end else begin
					answer_t want;
					want = pending_answers.pop_front();
					if (match_index !== want.idx)
						note_mismatch("match_index", match_index, want.idx);
					if (found !== want.hit)
						note_mismatch("found", found, want.hit);
				end
				if ($urandom_range(0, 49) == 0)
					out_calm = ~out_calm;
				out_hold = out_calm ? 0 : $urandom_range(0, 10);
			end
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_key_binary_search_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int               i;
		int               span;
		int               stride;
		int               run_key;
		int               probes;
		int               random_items;
		bit               wide;
		logic [CNT_W-1:0] count_val;

		random_items = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table in ascending order, a few entries pinned
		for (i = 0; i < DEFAULT_DEPTH; i++)
			fill_keys[i] = KEY_W'(i * 16 + $urandom_range(0, 15));
		fill_keys[0] = 16'h0000;
		fill_keys[1] = 16'h0013;
		fill_keys[2048] = 16'h8000;
		fill_keys[DEFAULT_DEPTH - 1] = 16'hFFF0;
		for (i = 0; i < DEFAULT_DEPTH; i++)
			send_beat(CMD_LOAD, POS_W'(i), fill_keys[i]);

		// directed plan
		for (i = 0; i < $size(PLAN); i++) begin
			case (PLAN[i].kind)
				ROW_COUNT: set_entry_count(PLAN[i].count);
				ROW_LOAD:  send_beat(CMD_LOAD, PLAN[i].pos, PLAN[i].key);
				default:   send_beat(CMD_LOOKUP, PLAN[i].pos, PLAN[i].key, PLAN[i].typed,
						PLAN[i].want_idx, PLAN[i].want_hit);
			endcase
		end

		// random phases: new count, reload the live prefix sorted, then lookups
		while (random_items < RANDOM_ITEMS) begin
			wide = ($urandom_range(0, 7) == 0);
			if (wide) begin
				case ($urandom_range(0, 2))
					0:       count_val = CNT_W'(DEFAULT_DEPTH);
					1:       count_val = CNT_W'($urandom_range(DEFAULT_DEPTH + 1, 8191));
					default: count_val = CNT_W'($urandom_range(65, DEFAULT_DEPTH));
				endcase
			end else begin
				count_val = CNT_W'($urandom_range(0, 48));
			end
			set_entry_count(count_val);
			span = live_entries;
			if (wide) begin
				// put back the ascending prefix that small phases overwrite
				for (i = 0; i < 64; i++) begin
					send_beat(CMD_LOAD, POS_W'(i), fill_keys[i]);
					random_items++;
				end
			end else begin
				// ascending run, zero steps give duplicates, top saturates
				stride = 65536 / (span + 1);
				run_key = $urandom_range(0, stride);
				for (i = 0; i < span; i++) begin
					send_beat(CMD_LOAD, POS_W'(i), KEY_W'(run_key > 65535 ? 65535 : run_key));
					run_key += $urandom_range(0, 2 * stride);
					random_items++;
				end
			end
			probes = $urandom_range(10, 30);
			for (i = 0; i < probes; i++) begin
				// stray loads into the low entries break the order now and then
				if ($urandom_range(0, 19) == 0)
					send_beat(CMD_LOAD, POS_W'($urandom_range(0, 63)), KEY_W'($urandom));
				else
					send_beat(CMD_LOOKUP, POS_W'($urandom), pick_key(span));
				random_items++;
			end
		end

		// drain, then allow for the last search to settle
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("sorted_key_binary_search_tb: PASS");
		else
			$display("sorted_key_binary_search_tb: FAIL");
		$finish;
	end

endmodule
